/* src/c3wf_pkg.sv */
// Shared types and constants for the 3x3 window convolution filter.
package c3wf_pkg;

    localparam int POS_BITS   = 11;
    localparam int IDX_BITS   = 3;
    localparam int KROW_BITS  = 48;
    localparam int COEF_BITS  = 16;
    localparam int RES_A_BITS = 29;
    localparam int RES_BC_BITS = 28;
    localparam int PIXEL_BITS = 8;

    typedef enum logic [IDX_BITS-1:0] {
        REG_KERNEL_TOP  = 3'd0,
        REG_KERNEL_MID  = 3'd1,
        REG_KERNEL_BOT  = 3'd2,
        REG_FRAME_W     = 3'd3,
        REG_FRAME_H     = 3'd4,
        REG_CHANNELS    = 3'd5,
        REG_KEEP        = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] sample_a;
        logic [PIXEL_BITS-1:0] sample_b;
        logic [PIXEL_BITS-1:0] sample_c;
    } pixel_t;

    typedef struct packed {
        logic signed [RES_A_BITS-1:0]  res_a;
        logic signed [RES_BC_BITS-1:0] res_b;
        logic signed [RES_BC_BITS-1:0] res_c;
        logic [POS_BITS-1:0]           pos_x;
        logic [POS_BITS-1:0]           pos_y;
        logic                          run_end;
    } result_t;

endpackage

/* src/conv2d_3x3_window_filter_unit.sv */
// Top level of the 3x3 window convolution filter with clamped borders.
// Throughput is one pixel per cycle while the output is not stalled; a row end or last-row
// pixel can yield extra results, which hold off the next pixel. A result passes from the
// window registers through the tap-product and row-sum registers into the output register.
// Line buffers sit in one RAM, read on pixel entry, written on stage 1 exit, with forwarding.
// Reset clears counters and valid bits and sets config defaults; line buffers are not cleared.
module conv2d_3x3_window_filter_unit #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pixel_valid,
    output logic                           pixel_stall,
    input  c3wf_pkg::pixel_t               pixel,
    output logic                           result_valid,
    input  logic                           result_stall,
    output c3wf_pkg::result_t              result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [c3wf_pkg::IDX_BITS-1:0]  cfg_index,
    input  logic [c3wf_pkg::KROW_BITS-1:0] cfg_data
);
    import c3wf_pkg::*;

    localparam int XB = $clog2(MAX_WIDTH);
    localparam int YB = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int PB = PIXEL_BITS;
    localparam int LW = 6 * PB;
    localparam int PW = PB + COEF_BITS + 1;
    localparam int RW = PW + 2;
    localparam int SW = PW + 6;

    logic [KROW_BITS-1:0] krow_reg [3];
    logic [11:0]          fw_reg;
    logic [11:0]          fh_reg;
    logic [1:0]           nch_reg;
    logic                 keep_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            krow_reg[0] <= '0;
            krow_reg[1] <= 48'd16777216;
            krow_reg[2] <= '0;
            fw_reg      <= 12'd640;
            fh_reg      <= 12'd480;
            nch_reg     <= 2'd3;
            keep_reg    <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_KERNEL_TOP: krow_reg[0] <= cfg_data;
                REG_KERNEL_MID: krow_reg[1] <= cfg_data;
                REG_KERNEL_BOT: krow_reg[2] <= cfg_data;
                REG_FRAME_W:    fw_reg      <= cfg_data[11:0];
                REG_FRAME_H:    fh_reg      <= cfg_data[11:0];
                REG_CHANNELS:   nch_reg     <= cfg_data[1:0];
                REG_KEEP:       keep_reg    <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Clamped frame size and position of the incoming pixel.
    logic [XB-1:0] wm1;
    logic [YB-1:0] hm1;
    logic [XB-1:0] col_reg;
    logic [XB-1:0] col_next;
    logic [YB-1:0] row_reg;
    logic [YB-1:0] row_next;
    logic [XB-1:0] cx;
    logic [YB-1:0] cy;

    always_comb
    begin
        if (fw_reg == 12'd0)
            wm1 = '0;
        else if ({20'd0, fw_reg} > 32'(MAX_WIDTH))
            wm1 = XB'(MAX_WIDTH - 1);
        else
            wm1 = XB'({20'd0, fw_reg} - 32'd1);
        if (fh_reg == 12'd0)
            hm1 = '0;
        else if ({20'd0, fh_reg} > 32'(MAX_HEIGHT))
            hm1 = YB'(MAX_HEIGHT - 1);
        else
            hm1 = YB'({20'd0, fh_reg} - 32'd1);
        cx = (col_reg > wm1) ? wm1 : col_reg;
        cy = (row_reg > hm1) ? hm1 : row_reg;
        if (cx == wm1)
        begin
            col_next = '0;
            row_next = (cy == hm1) ? '0 : cy + YB'(1);
        end
        else
        begin
            col_next = cx + XB'(1);
            row_next = cy;
        end
    end

    // Pipeline control.
    logic pipe_en;
    logic s1_valid_reg;
    logic s1_adv;
    logic in_fire;
    logic [3:0] s2_mask_reg;
    logic s2_free;

    assign pipe_en     = !result_valid || !result_stall;
    assign s2_free     = (s2_mask_reg == 4'd0) || ($onehot(s2_mask_reg) && pipe_en);
    assign s1_adv      = s1_valid_reg && s2_free;
    assign pixel_stall = s1_valid_reg && !s2_free;
    assign in_fire     = pixel_valid && !pixel_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_fire)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Stage 1: line buffer read returns, forwarding covers a one-column frame.
    logic [PB-1:0] s1_px_reg [3];
    logic [XB-1:0] s1_cx_reg;
    logic [YB-1:0] s1_cy_reg;
    logic [3:0]    s1_mask_reg;
    logic [3:0]    s1_mask_next;
    logic          fwd_reg;
    logic [LW-1:0] fwd_data_reg;
    logic [LW-1:0] ram_rd;
    logic [LW-1:0] line_word;
    logic [LW-1:0] wr_word;

    assign line_word = fwd_reg ? fwd_data_reg : ram_rd;
    assign wr_word   = {line_word[3*PB-1:0], s1_px_reg[0], s1_px_reg[1], s1_px_reg[2]};

    always_comb
    begin
        s1_mask_next[0] = (cy != '0) && (cx != '0);
        s1_mask_next[1] = (cy != '0) && (cx == wm1);
        s1_mask_next[2] = (cy == hm1) && (cx != '0);
        s1_mask_next[3] = (cy == hm1) && (cx == wm1);
    end

    c3wf_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_cx_reg),
        .wr_data (wr_word),
        .rd_en   (in_fire),
        .rd_addr (cx),
        .rd_data (ram_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
                fwd_reg      <= s1_adv && (s1_cx_reg == cx);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
                fwd_reg      <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_px_reg[0] <= PB'(pixel.sample_a);
            s1_px_reg[1] <= PB'(pixel.sample_b);
            s1_px_reg[2] <= PB'(pixel.sample_c);
            s1_cx_reg    <= cx;
            s1_cy_reg    <= cy;
            s1_mask_reg  <= s1_mask_next;
            fwd_data_reg <= wr_word;
        end
    end

    // Stage 2: window registers and emission of up to four results.
    logic [PB-1:0] win_reg [3][3][3];
    logic [XB-1:0] s2_cx_reg;
    logic [YB-1:0] s2_cy_reg;
    logic [XB-1:0] s2_wm1_reg;
    logic [YB-1:0] s2_hm1_reg;
    logic [3:0]    s2_mask_next;
    logic [1:0]    k_sel;
    logic [3:0]    mask_rest;
    logic [1:0]    rsel [3];
    logic [1:0]    csel [3];
    logic          emit;

    assign emit = (s2_mask_reg != 4'd0) && pipe_en;

    always_comb
    begin
        if (s2_mask_reg[0])
            k_sel = 2'd0;
        else if (s2_mask_reg[1])
            k_sel = 2'd1;
        else if (s2_mask_reg[2])
            k_sel = 2'd2;
        else
            k_sel = 2'd3;
        mask_rest = s2_mask_reg & ~(4'd1 << k_sel);
        if (!k_sel[1])
        begin
            rsel[0] = (s2_cy_reg >= YB'(2)) ? 2'd0 : 2'd1;
            rsel[1] = 2'd1;
        end
        else
        begin
            rsel[0] = (s2_hm1_reg != '0) ? 2'd1 : 2'd2;
            rsel[1] = 2'd2;
        end
        rsel[2] = 2'd2;
        if (!k_sel[0])
        begin
            csel[0] = (s2_cx_reg >= XB'(2)) ? 2'd0 : 2'd1;
            csel[1] = 2'd1;
        end
        else
        begin
            csel[0] = (s2_wm1_reg != '0) ? 2'd1 : 2'd2;
            csel[1] = 2'd2;
        end
        csel[2] = 2'd2;
        if (s1_adv)
            s2_mask_next = s1_mask_reg;
        else if (emit)
            s2_mask_next = mask_rest;
        else
            s2_mask_next = s2_mask_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_mask_reg <= '0;
        else
            s2_mask_reg <= s2_mask_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int ch = 0; ch < 3; ch++)
                begin
                    win_reg[r][0][ch] <= win_reg[r][1][ch];
                    win_reg[r][1][ch] <= win_reg[r][2][ch];
                end
            end
            for (int ch = 0; ch < 3; ch++)
            begin
                win_reg[0][2][ch] <= line_word[LW-1-PB*ch -: PB];
                win_reg[1][2][ch] <= line_word[3*PB-1-PB*ch -: PB];
                win_reg[2][2][ch] <= s1_px_reg[ch];
            end
            s2_cx_reg  <= s1_cx_reg;
            s2_cy_reg  <= s1_cy_reg;
            s2_wm1_reg <= wm1;
            s2_hm1_reg <= hm1;
        end
    end

    // Stage 3: tap products.
    logic                 s3_valid_reg;
    logic signed [PW-1:0] prod_reg [3][3][3];
    logic [POS_BITS-1:0]  s3_x_reg;
    logic [POS_BITS-1:0]  s3_y_reg;
    logic                 s3_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (pipe_en)
            s3_valid_reg <= s2_mask_reg != 4'd0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            for (int j = 0; j < 3; j++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    for (int ch = 0; ch < 3; ch++)
                    begin
                        prod_reg[j][i][ch] <=
                            PW'($signed({1'b0, win_reg[rsel[j]][csel[i]][ch]})
                                * $signed(krow_reg[j][COEF_BITS*i +: COEF_BITS]));
                    end
                end
            end
            s3_x_reg    <= k_sel[0] ? POS_BITS'(s2_wm1_reg) : POS_BITS'(s2_cx_reg - XB'(1));
            s3_y_reg    <= k_sel[1] ? POS_BITS'(s2_hm1_reg) : POS_BITS'(s2_cy_reg - YB'(1));
            s3_last_reg <= mask_rest == 4'd0;
        end
    end

    // Stage 4: row sums, with unused channels zeroed.
    logic                 s4_valid_reg;
    logic signed [RW-1:0] rsum_reg [3][3];
    logic [POS_BITS-1:0]  s4_x_reg;
    logic [POS_BITS-1:0]  s4_y_reg;
    logic                 s4_last_reg;
    logic [1:0]           nch;

    assign nch = (nch_reg == 2'd0) ? 2'd1 : nch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (pipe_en)
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en && s3_valid_reg)
        begin
            for (int j = 0; j < 3; j++)
            begin
                for (int ch = 0; ch < 3; ch++)
                begin
                    if (2'(ch) < nch)
                        rsum_reg[j][ch] <= RW'(prod_reg[j][0][ch]) + RW'(prod_reg[j][1][ch])
                                           + RW'(prod_reg[j][2][ch]);
                    else
                        rsum_reg[j][ch] <= '0;
                end
            end
            s4_x_reg    <= s3_x_reg;
            s4_y_reg    <= s3_y_reg;
            s4_last_reg <= s3_last_reg;
        end
    end

    // Stage 5: channel totals into the output register.
    logic signed [SW-1:0] csum [3];
    logic signed [SW-1:0] tot;
    logic                 sum_mode;
    logic                 out_valid_reg;
    result_t              out_reg;

    assign sum_mode = !keep_reg || (nch == 2'd1);

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            csum[ch] = SW'(rsum_reg[0][ch]) + SW'(rsum_reg[1][ch]) + SW'(rsum_reg[2][ch]);
        end
        tot = csum[0] + csum[1] + csum[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pipe_en)
            out_valid_reg <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en && s4_valid_reg)
        begin
            if (sum_mode)
            begin
                out_reg.res_a <= RES_A_BITS'(tot);
                out_reg.res_b <= '0;
                out_reg.res_c <= '0;
            end
            else
            begin
                out_reg.res_a <= RES_A_BITS'(csum[0]);
                out_reg.res_b <= RES_BC_BITS'(csum[1]);
                out_reg.res_c <= RES_BC_BITS'(csum[2]);
            end
            out_reg.pos_x   <= s4_x_reg;
            out_reg.pos_y   <= s4_y_reg;
            out_reg.run_end <= s4_last_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_fwd_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> s1_valid_reg)
        else $error("Forwarded line data without an item in stage 1.");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |-> (s2_mask_reg == 4'd0) || (pipe_en && $onehot(s2_mask_reg)))
        else $error("Window advanced while results were still pending.");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (k_sel == 2'd3)) |-> (mask_rest == 4'd0))
        else $error("Corner result was not the final result of its transfer.");

endmodule

/* src/c3wf_ram.sv */
// Generic simple dual-port RAM with a registered read port.
module c3wf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
